FILE: src/jsesc_pkg.sv
package jsesc_pkg;

	// One input word: a raw byte of the string and its framing flags.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_of_string;
		logic       no_byte;
	} in_word_t;

	// One output word: a byte of the quoted text and its status.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
		logic       string_done;
		logic [2:0] error_code;
	} out_word_t;

	// Error codes reported with the closing quote.
	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_CONT       = 3'd1;
	localparam logic [2:0] ERR_CODE       = 3'd2;
	localparam logic [2:0] ERR_LEAD       = 3'd3;
	localparam logic [2:0] ERR_INCOMPLETE = 3'd4;

	// How the byte of a job is written out.
	localparam logic [1:0] KIND_PLAIN = 2'd0;
	localparam logic [1:0] KIND_PAIR  = 2'd1;
	localparam logic [1:0] KIND_UNI   = 2'd2;

	// Code point limits.
	localparam logic [20:0] CP_MIN_2   = 21'h000080;
	localparam logic [20:0] CP_MIN_3   = 21'h000800;
	localparam logic [20:0] CP_MIN_4   = 21'h010000;
	localparam logic [20:0] CP_MAX     = 21'h10FFFF;
	localparam logic [20:0] CP_SURR_LO = 21'h00D800;
	localparam logic [20:0] CP_SURR_HI = 21'h00DFFF;

	// Characters used in the output text.
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	// Work handed from the front to the back through the queue.
	typedef struct packed {
		logic       open;
		logic       has_byte;
		logic [1:0] kind;
		logic [7:0] byte_val;
		logic       close;
		logic [2:0] err;
	} job_t;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	// Lowercase hexadecimal digit for one nibble.
	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		logic [7:0] res;
		if (nib < 4'd10) begin
			res = 8'h30 + {4'd0, nib};
		end else begin
			res = 8'h57 + {4'd0, nib};
		end
		return res;
	endfunction

endpackage

FILE: src/jsesc_front.sv
module jsesc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  jsesc_pkg::in_word_t item,
	input  logic               q_full,
	output logic               push,
	output jsesc_pkg::job_t    job
);
	import jsesc_pkg::*;

	logic        in_string_q;
	logic [1:0]  pend_q;
	logic [1:0]  seq_q;
	logic [20:0] cp_q;
	logic [2:0]  err_q;

	logic        accept;
	logic [1:0]  pend_eff, seq_eff, pend_nx, seq_nx;
	logic [20:0] cp_eff, cp_nx, cp_shift, minimum;
	logic [2:0]  err_eff, err_nx, err_fin;
	logic [7:0]  b;
	logic [1:0]  kind;
	logic [7:0]  esc;

	// A word is taken whenever the queue has room.
	assign item_stall = q_full;
	assign accept     = item_valid && !q_full;
	assign b          = item.data_byte;

	// UTF-8 check of the incoming byte; a new string starts from a clean state.
	always_comb begin
		pend_eff = in_string_q ? pend_q : 2'd0;
		seq_eff  = in_string_q ? seq_q : 2'd0;
		cp_eff   = in_string_q ? cp_q : 21'd0;
		err_eff  = in_string_q ? err_q : ERR_NONE;
		pend_nx  = pend_eff;
		seq_nx   = seq_eff;
		cp_nx    = cp_eff;
		err_nx   = err_eff;
		cp_shift = {cp_eff[14:0], b[5:0]};
		minimum  = (seq_eff == 2'd1) ? CP_MIN_2 : (seq_eff == 2'd2) ? CP_MIN_3 : CP_MIN_4;
		if (!item.no_byte && err_eff == ERR_NONE) begin
			if (pend_eff != 2'd0) begin
				if (b[7:6] != 2'b10) begin
					err_nx = ERR_CONT;
				end else begin
					cp_nx   = cp_shift;
					pend_nx = pend_eff - 2'd1;
					if (pend_nx == 2'd0 && (cp_shift < minimum || cp_shift > CP_MAX ||
						(cp_shift >= CP_SURR_LO && cp_shift <= CP_SURR_HI))) begin
						err_nx = ERR_CODE;
					end
				end
			end else if (b[7]) begin
				if (b >= 8'hC2 && b <= 8'hDF) begin
					pend_nx = 2'd1;
					seq_nx  = 2'd1;
					cp_nx   = {16'd0, b[4:0]};
				end else if (b >= 8'hE0 && b <= 8'hEF) begin
					pend_nx = 2'd2;
					seq_nx  = 2'd2;
					cp_nx   = {17'd0, b[3:0]};
				end else if (b >= 8'hF0 && b <= 8'hF4) begin
					pend_nx = 2'd3;
					seq_nx  = 2'd3;
					cp_nx   = {18'd0, b[2:0]};
				end else begin
					err_nx = ERR_LEAD;
				end
			end
		end
		err_fin = (item.last_of_string && err_nx == ERR_NONE && pend_nx != 2'd0) ?
			ERR_INCOMPLETE : err_nx;
	end

	// Sort the byte into plain, two-byte escape or unicode escape.
	always_comb begin
		kind = KIND_PLAIN;
		esc  = b;
		case (b)
			8'h22: begin kind = KIND_PAIR; esc = CH_QUOTE; end
			8'h5C: begin kind = KIND_PAIR; esc = CH_BSL; end
			8'h08: begin kind = KIND_PAIR; esc = 8'h62; end
			8'h0C: begin kind = KIND_PAIR; esc = 8'h66; end
			8'h0A: begin kind = KIND_PAIR; esc = 8'h6E; end
			8'h0D: begin kind = KIND_PAIR; esc = 8'h72; end
			8'h09: begin kind = KIND_PAIR; esc = 8'h74; end
			default: begin
				if (b < 8'h20) begin
					kind = KIND_UNI;
				end
			end
		endcase
	end

	// Assemble the job; a word that produces no output is not queued.
	always_comb begin
		job.open     = !in_string_q;
		job.has_byte = !item.no_byte;
		job.kind     = kind;
		job.byte_val = esc;
		job.close    = item.last_of_string;
		job.err      = err_fin;
		push = accept && (!in_string_q || !item.no_byte || item.last_of_string);
	end

	// Validation state; the end of a string returns it to the idle values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_string_q <= 1'b0;
			pend_q      <= 2'd0;
			seq_q       <= 2'd0;
			cp_q        <= 21'd0;
			err_q       <= ERR_NONE;
		end else if (accept) begin
			if (item.last_of_string) begin
				in_string_q <= 1'b0;
				pend_q      <= 2'd0;
				seq_q       <= 2'd0;
				cp_q        <= 21'd0;
				err_q       <= ERR_NONE;
			end else begin
				in_string_q <= 1'b1;
				pend_q      <= pend_nx;
				seq_q       <= seq_nx;
				cp_q        <= cp_nx;
				err_q       <= err_nx;
			end
		end
	end

endmodule

FILE: src/jsesc_queue.sv
module jsesc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  jsesc_pkg::job_t din,
	output logic            full,
	input  logic            pop,
	output jsesc_pkg::job_t dout,
	output logic            empty
);
	import jsesc_pkg::*;

	job_t                   mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_q;
	logic [QUEUE_PTR_W-1:0] rd_q;
	logic [QUEUE_PTR_W:0]   cnt_q;

	assign full  = (cnt_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rd_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/jsesc_back.sv
module jsesc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_valid,
	input  jsesc_pkg::job_t      job,
	output logic                 job_pop,
	output logic                 text_valid,
	input  logic                 text_stall,
	output jsesc_pkg::out_word_t text
);
	import jsesc_pkg::*;

	logic      [2:0] pos_q;
	logic            out_valid_q;
	out_word_t       out_word_q;

	logic       emit;
	logic       is_last;
	logic [2:0] nbody;
	logic [3:0] total;
	logic [2:0] q;
	logic [7:0] body;
	out_word_t  word;

	assign emit    = job_valid && (!out_valid_q || !text_stall);
	assign job_pop = emit && is_last;

	// Length of the run for the current job and the position within it.
	always_comb begin
		nbody = 3'd0;
		if (job.has_byte) begin
			unique case (job.kind)
				KIND_PLAIN: nbody = 3'd1;
				KIND_PAIR:  nbody = 3'd2;
				KIND_UNI:   nbody = 3'd6;
				default:    nbody = 3'd1;
			endcase
		end
		total   = {3'd0, job.open} + {1'b0, nbody} + {3'd0, job.close};
		is_last = ({1'b0, pos_q} == total - 4'd1);
		q       = pos_q - {2'd0, job.open};
	end

	// Byte of the escaped text at the current position.
	always_comb begin
		body = job.byte_val;
		unique case (job.kind)
			KIND_PLAIN: body = job.byte_val;
			KIND_PAIR:  body = (q == 3'd0) ? CH_BSL : job.byte_val;
			KIND_UNI: begin
				case (q)
					3'd0:    body = CH_BSL;
					3'd1:    body = CH_U;
					3'd2:    body = CH_ZERO;
					3'd3:    body = CH_ZERO;
					3'd4:    body = hex_digit(job.byte_val[7:4]);
					default: body = hex_digit(job.byte_val[3:0]);
				endcase
			end
			default: body = job.byte_val;
		endcase
	end

	// Output word with its run and string flags.
	always_comb begin
		if (job.open && pos_q == 3'd0) begin
			word.out_byte = CH_QUOTE;
		end else if (q < nbody) begin
			word.out_byte = body;
		end else begin
			word.out_byte = CH_QUOTE;
		end
		word.last_of_run = is_last;
		word.string_done = is_last && job.close;
		word.error_code  = (is_last && job.close) ? job.err : ERR_NONE;
	end

	// Position counter within the current job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 3'd0;
		end else if (emit) begin
			pos_q <= is_last ? 3'd0 : pos_q + 3'd1;
		end
	end

	// Output register, reloaded from the queued job whenever the previous word has gone.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!text_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_word_q <= word;
		end
	end

	assign text_valid = out_valid_q;
	assign text       = out_word_q;

endmodule

FILE: src/json_string_escape_utf8_check.sv
// JSON string quoter with UTF-8 checking. Each input word carries one raw byte of a
// string (or none, for an empty string) and each output word one byte of the quoted
// text: an opening quote before the first byte, two-byte escapes for quote, backslash,
// BS, FF, LF, CR and TAB, \u00xx for other control bytes, and a closing quote flagged
// with string_done that carries the first UTF-8 error of the string (0 means clean);
// downstream must discard a string with a non-zero error_code, as its bytes are
// already out. The input takes one word per cycle while the four-entry job queue has
// room, and the output gives one byte per cycle unless stalled; a plain byte
// becomes one output word and an escape two or six, plus one each for the quotes. An
// accepted byte is registered in the job queue and then in the output register.
module json_string_escape_utf8_check (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  jsesc_pkg::in_word_t  item,
	output logic                 text_valid,
	input  logic                 text_stall,
	output jsesc_pkg::out_word_t text
);
	import jsesc_pkg::*;

	logic push, q_full, q_empty, job_pop;
	job_t job_in, job_out;

	// Front: takes words, checks UTF-8 and classifies bytes.
	jsesc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_full     (q_full),
		.push       (push),
		.job        (job_in)
	);

	// Short queue between the two halves.
	jsesc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (job_in),
		.full   (q_full),
		.pop    (job_pop),
		.dout   (job_out),
		.empty  (q_empty)
	);

	// Back: expands each job into output bytes.
	jsesc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (!q_empty),
		.job        (job_out),
		.job_pop    (job_pop),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text       (text)
	);

`ifndef NO_ASSERTIONS
	// The closing quote always ends the run of its word.
	a_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && text.string_done |-> text.last_of_run)
		else $error("closing quote not marked as end of run");

	// An error is only reported on the closing quote, and only with a defined code.
	a_err_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && text.error_code != ERR_NONE |->
			text.string_done && (text.error_code == ERR_CONT ||
			text.error_code == ERR_CODE || text.error_code == ERR_LEAD ||
			text.error_code == ERR_INCOMPLETE))
		else $error("error code outside the closing quote or undefined");

	// The back never takes a job from an empty queue.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> !q_empty)
		else $error("job taken from empty queue");
`endif

endmodule

FILE: test/json_string_escape_utf8_check_tb.sv
`timescale 1ns / 1ps

module json_string_escape_utf8_check_tb;
	import jsesc_pkg::*;

	localparam int RANDOM_WORDS = 165;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 20;
	localparam int REPORT_MAX   = 10;

	// Raw control bytes that have a short escape, and the letters that name them.
	localparam logic [7:0] RAW_BS  = 8'h08;
	localparam logic [7:0] RAW_TAB = 8'h09;
	localparam logic [7:0] RAW_LF  = 8'h0A;
	localparam logic [7:0] RAW_FF  = 8'h0C;
	localparam logic [7:0] RAW_CR  = 8'h0D;
	localparam logic [7:0] CH_B    = 8'h62;
	localparam logic [7:0] CH_F    = 8'h66;
	localparam logic [7:0] CH_N    = 8'h6E;
	localparam logic [7:0] CH_R    = 8'h72;
	localparam logic [7:0] CH_T    = 8'h74;
	localparam logic [7:0] CH_A_LC = 8'h61;

	// Patterns of back-pressure on the text side.
	localparam int STALL_NONE  = 0;
	localparam int STALL_LIGHT = 1;
	localparam int STALL_HEAVY = 2;
	localparam int STALL_RUNS  = 3;

	// Kinds of malformed UTF-8 fragment.
	localparam int BAD_TRUNC      = 0;
	localparam int BAD_CONT       = 1;
	localparam int BAD_OVERLONG2  = 2;
	localparam int BAD_OVERLONG3  = 3;
	localparam int BAD_OVERLONG4  = 4;
	localparam int BAD_SURROGATE  = 5;
	localparam int BAD_TOO_BIG    = 6;
	localparam int BAD_LONE       = 7;

	// Quoting predictor and the store of text words it expects.
	class text_scoreboard;
		out_word_t   expected_q[$];
		bit          in_str;
		logic [1:0]  cont_left;
		logic [1:0]  seq_len;
		logic [20:0] cp_acc;
		logic [2:0]  first_err;
		int          mismatches;
		int          words_checked;
		int          strings_closed;
		int          strings_bad;

		function new();
			in_str = 1'b0;
			clear_utf8();
			mismatches = 0;
			words_checked = 0;
			strings_closed = 0;
			strings_bad = 0;
		endfunction

		function void clear_utf8();
			cont_left = 2'd0;
			seq_len = 2'd0;
			cp_acc = 21'd0;
			first_err = ERR_NONE;
		endfunction

		function void push_text(logic [7:0] b);
			out_word_t w;
			w = '0;
			w.out_byte = b;
			expected_q = {expected_q, w};
		endfunction

		function logic [7:0] hex_char(logic [3:0] nib);
			logic [7:0] c;
			if (nib < 4'd10) begin
				c = CH_ZERO + {4'd0, nib};
			end else begin
				c = CH_A_LC + {4'd0, nib - 4'd10};
			end
			return c;
		endfunction

		// Track the UTF-8 decoder; only the first error of a string is kept.
		function void check_utf8(logic [7:0] b);
			logic [20:0] floor_cp;
			if (first_err != ERR_NONE) return;
			if (cont_left != 2'd0) begin
				if (b[7:6] != 2'b10) begin
					first_err = ERR_CONT;
					return;
				end
				cp_acc = {cp_acc[14:0], b[5:0]};
				cont_left = cont_left - 2'd1;
				if (cont_left != 2'd0) return;
				case (seq_len)
					2'd1: floor_cp = CP_MIN_2;
					2'd2: floor_cp = CP_MIN_3;
					default: floor_cp = CP_MIN_4;
				endcase
				if (cp_acc < floor_cp || cp_acc > CP_MAX ||
				    (cp_acc >= CP_SURR_LO && cp_acc <= CP_SURR_HI))
					first_err = ERR_CODE;
				return;
			end
			if (b <= 8'h7F) return;
			if (b >= 8'hC2 && b <= 8'hDF) begin
				cont_left = 2'd1;
				seq_len = 2'd1;
				cp_acc = {16'd0, b[4:0]};
			end else if (b >= 8'hE0 && b <= 8'hEF) begin
				cont_left = 2'd2;
				seq_len = 2'd2;
				cp_acc = {17'd0, b[3:0]};
			end else if (b >= 8'hF0 && b <= 8'hF4) begin
				cont_left = 2'd3;
				seq_len = 2'd3;
				cp_acc = {18'd0, b[2:0]};
			end else begin
				first_err = ERR_LEAD;
			end
		endfunction

		// Expected text for one raw byte.
		function void escape(logic [7:0] b);
			logic [7:0] pair;
			case (b)
				CH_QUOTE: pair = CH_QUOTE;
				CH_BSL:   pair = CH_BSL;
				RAW_BS:   pair = CH_B;
				RAW_FF:   pair = CH_F;
				RAW_LF:   pair = CH_N;
				RAW_CR:   pair = CH_R;
				RAW_TAB:  pair = CH_T;
				default:  pair = 8'h00;
			endcase
			if (pair != 8'h00) begin
				push_text(CH_BSL);
				push_text(pair);
			end else if (b < 8'h20) begin
				push_text(CH_BSL);
				push_text(CH_U);
				push_text(CH_ZERO);
				push_text(CH_ZERO);
				push_text(hex_char(b[7:4]));
				push_text(hex_char(b[3:0]));
			end else begin
				push_text(b);
			end
		endfunction

		// An input word has been accepted: queue the text it causes.
		function void note_word(in_word_t w);
			int        first;
			out_word_t tail;
			first = expected_q.size();
			if (!in_str) begin
				push_text(CH_QUOTE);
				in_str = 1'b1;
				clear_utf8();
			end
			if (!w.no_byte) begin
				check_utf8(w.data_byte);
				escape(w.data_byte);
			end
			if (w.last_of_string) begin
				if (first_err == ERR_NONE && cont_left != 2'd0) first_err = ERR_INCOMPLETE;
				push_text(CH_QUOTE);
				tail = expected_q[expected_q.size() - 1];
				tail.string_done = 1'b1;
				tail.error_code = first_err;
				expected_q[expected_q.size() - 1] = tail;
				strings_closed++;
				if (first_err != ERR_NONE) strings_bad++;
				in_str = 1'b0;
				clear_utf8();
			end
			if (expected_q.size() > first) begin
				tail = expected_q[expected_q.size() - 1];
				tail.last_of_run = 1'b1;
				expected_q[expected_q.size() - 1] = tail;
			end
		endfunction

		// A text word has been accepted: compare it with the oldest expectation.
		function void check_word(out_word_t got);
			out_word_t want;
			bit        bad;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected text word: byte %h last_of_run %b %s %b %s %0d",
						got.out_byte, got.last_of_run, "string_done", got.string_done,
						"error_code", got.error_code);
				return;
			end
			want = expected_q.pop_front();
			bad = (got.out_byte !== want.out_byte) || (got.last_of_run !== want.last_of_run) ||
				(got.string_done !== want.string_done) || (got.error_code !== want.error_code);
			if (bad) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("text word %0d: expected byte %h last_of_run %b %s %b %s %0d",
						words_checked, want.out_byte, want.last_of_run, "string_done",
						want.string_done, "error_code", want.error_code);
					$display("text word %0d:      got byte %h last_of_run %b %s %b %s %0d",
						words_checked, got.out_byte, got.last_of_run, "string_done",
						got.string_done, "error_code", got.error_code);
				end
			end
			words_checked++;
		endfunction
	endclass

	logic      clk;
	logic      arst_n = 1'b0;
	logic      item_valid = 1'b0;
	logic      item_stall;
	in_word_t  item = '0;
	logic      text_valid;
	logic      text_stall = 1'b0;
	out_word_t text;

	text_scoreboard sb;
	in_word_t       str_buf[$];
	int             burst_left = 0;
	int             words_sent = 0;
	int             directed_words = 0;
	int             cycle_count = 0;
	int             stall_mode = STALL_NONE;
	int             stall_phase = 0;
	int             stall_hold = 0;
	bit             stall_level = 1'b0;

	json_string_escape_utf8_check dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item      (item),
		.text_valid(text_valid),
		.text_stall(text_stall),
		.text      (text)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Back-pressure on the text side, in patterns chosen at random.
	always @(posedge clk) begin
		if (stall_phase == 0) begin
			stall_mode = $urandom_range(STALL_NONE, STALL_RUNS);
			stall_phase = $urandom_range(16, 96);
		end
		stall_phase--;
		case (stall_mode)
			STALL_NONE:  text_stall <= 1'b0;
			STALL_LIGHT: text_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: text_stall <= ($urandom_range(0, 9) < 7);
			default: begin
				if (stall_hold == 0) begin
					stall_hold = $urandom_range(1, 8);
					stall_level = ~stall_level;
				end
				stall_hold--;
				text_stall <= stall_level;
			end
		endcase
	end

	// Every accepted text word goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && text_valid && !text_stall) sb.check_word(text);
	end

	// Present one input word, in bursts with random gaps, and wait for its acceptance.
	task automatic send_word(input in_word_t w);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
			if (gap != 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		item_valid <= 1'b1;
		item <= w;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		sb.note_word(w);
		burst_left--;
		words_sent++;
	endtask

	function void push_byte(input logic [7:0] b);
		in_word_t w;
		w.data_byte = b;
		w.last_of_string = 1'b0;
		w.no_byte = 1'b0;
		str_buf = {str_buf, w};
	endfunction

	// A word with no byte; its data field is junk that the block must ignore.
	function void push_blank();
		in_word_t w;
		w.data_byte = 8'($urandom);
		w.last_of_string = 1'b0;
		w.no_byte = 1'b1;
		str_buf = {str_buf, w};
	endfunction

	// Close the buffered string, either on its last byte or with a bare end marker.
	task automatic send_string(input bit marker_ok);
		in_word_t w;
		int       i;
		if (str_buf.size() == 0 || (marker_ok && $urandom_range(0, 4) == 0)) begin
			w.data_byte = 8'($urandom);
			w.last_of_string = 1'b1;
			w.no_byte = 1'b1;
			str_buf = {str_buf, w};
		end else begin
			w = str_buf[str_buf.size() - 1];
			w.last_of_string = 1'b1;
			str_buf[str_buf.size() - 1] = w;
		end
		for (i = 0; i < str_buf.size(); i++) send_word(str_buf[i]);
		str_buf.delete();
	endtask

	function void push_utf8_char(input logic [20:0] cp);
		if (cp < 21'h80) begin
			push_byte(cp[7:0]);
		end else if (cp < 21'h800) begin
			push_byte({3'b110, cp[10:6]});
			push_byte({2'b10, cp[5:0]});
		end else if (cp < 21'h10000) begin
			push_byte({4'b1110, cp[15:12]});
			push_byte({2'b10, cp[11:6]});
			push_byte({2'b10, cp[5:0]});
		end else begin
			push_byte({5'b11110, cp[20:18]});
			push_byte({2'b10, cp[17:12]});
			push_byte({2'b10, cp[11:6]});
			push_byte({2'b10, cp[5:0]});
		end
	endfunction

	// A legal code point, weighted towards ASCII and the bytes that need escaping.
	function logic [20:0] random_char();
		logic [20:0] cp;
		case ($urandom_range(0, 7))
			4: cp = 21'($urandom_range(21'h80, 21'h7FF));
			5: begin
				cp = 21'($urandom_range(21'h800, 21'hFFFF));
				if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) cp = cp ^ 21'h1000;
			end
			6: cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
			7: begin
				case ($urandom_range(0, 3))
					0: cp = {13'd0, CH_QUOTE};
					1: cp = {13'd0, CH_BSL};
					2: cp = 21'h7F;
					default: cp = 21'($urandom_range(0, 31));
				endcase
			end
			default: cp = 21'($urandom_range(0, 127));
		endcase
		return cp;
	endfunction

	function logic [7:0] cont_byte();
		logic [7:0] low;
		low = 8'($urandom_range(0, 63));
		return 8'h80 | low;
	endfunction

	function logic [7:0] lead_byte(input int extra);
		logic [7:0] b;
		if (extra == 1) b = 8'($urandom_range(8'hC2, 8'hDF));
		else if (extra == 2) b = 8'($urandom_range(8'hE1, 8'hEC));
		else b = 8'($urandom_range(8'hF1, 8'hF3));
		return b;
	endfunction

	// One malformed UTF-8 fragment of a random kind.
	function void push_bad_fragment();
		int         kind;
		int         extra;
		logic [7:0] low;
		kind = $urandom_range(BAD_TRUNC, BAD_LONE);
		extra = $urandom_range(1, 3);
		case (kind)
			BAD_TRUNC: begin
				push_byte(lead_byte(extra));
				repeat ($urandom_range(0, extra - 1)) push_byte(cont_byte());
			end
			BAD_CONT: begin
				push_byte(lead_byte(extra));
				if ($urandom_range(0, 1) == 0) push_byte(8'($urandom_range(8'h00, 8'h7F)));
				else push_byte(8'($urandom_range(8'hC0, 8'hFF)));
			end
			BAD_OVERLONG2: begin
				push_byte(8'($urandom_range(8'hC0, 8'hC1)));
				push_byte(cont_byte());
			end
			BAD_OVERLONG3: begin
				low = 8'($urandom_range(0, 31));
				push_byte(8'hE0);
				push_byte(8'h80 | low);
				push_byte(cont_byte());
			end
			BAD_OVERLONG4: begin
				low = 8'($urandom_range(0, 15));
				push_byte(8'hF0);
				push_byte(8'h80 | low);
				push_byte(cont_byte());
				push_byte(cont_byte());
			end
			BAD_SURROGATE: begin
				low = 8'($urandom_range(0, 31));
				push_byte(8'hED);
				push_byte(8'hA0 | low);
				push_byte(cont_byte());
			end
			BAD_TOO_BIG: begin
				if ($urandom_range(0, 1) == 0) begin
					push_byte(8'hF4);
					push_byte(8'($urandom_range(8'h90, 8'hBF)));
					push_byte(cont_byte());
					push_byte(cont_byte());
				end else begin
					push_byte(8'($urandom_range(8'hF5, 8'hFF)));
				end
			end
			default: push_byte(cont_byte());
		endcase
	endfunction

	// Short strings covering the edge cases one by one.
	task automatic directed_strings();
		// Empty string.
		send_string(1'b0);
		// Byte-less words before the first byte: only the first opens the string.
		push_blank();
		push_blank();
		push_byte(8'h41);
		send_string(1'b0);
		// Every short escape, the control range ends and the first printable byte.
		push_byte(CH_QUOTE);
		push_byte(CH_BSL);
		push_byte(RAW_BS);
		push_byte(RAW_FF);
		push_byte(RAW_LF);
		push_byte(RAW_CR);
		push_byte(RAW_TAB);
		push_byte(8'h00);
		push_byte(8'h1F);
		push_byte(8'h20);
		send_string(1'b0);
		// Smallest two-byte and largest four-byte code points.
		push_byte(8'hC2);
		push_byte(8'h80);
		push_byte(8'hF4);
		push_byte(8'h8F);
		push_byte(8'hBF);
		push_byte(8'hBF);
		send_string(1'b0);
		// Surrogate.
		push_byte(8'hED);
		push_byte(8'hA0);
		push_byte(8'h80);
		send_string(1'b0);
		// Bad continuation.
		push_byte(8'hC3);
		push_byte(8'h41);
		send_string(1'b0);
		// Sequence cut off by the end of the string.
		push_byte(8'hF0);
		send_string(1'b0);
		// Illegal lead byte.
		push_byte(8'hFF);
		send_string(1'b0);
	endtask

	// Mostly well-formed strings, with raw noise and broken sequences mixed in.
	task automatic random_string();
		int kind;
		int n;
		int i;
		kind = $urandom_range(0, 19);
		n = $urandom_range(0, 6);
		if (kind < 13) begin
			for (i = 0; i < n; i++) begin
				if ($urandom_range(0, 11) == 0) push_blank();
				push_utf8_char(random_char());
			end
		end else if (kind < 16) begin
			for (i = 0; i <= n; i++) push_byte(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(0, 3)) push_utf8_char(random_char());
			push_bad_fragment();
			repeat ($urandom_range(0, 3)) push_utf8_char(random_char());
		end
		send_string(1'b1);
	endtask

	// Guard against a hang.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d text words still expected", cycle_count,
			sb.expected_q.size());
		$display("json_string_escape_utf8_check verification failed");
		$finish;
	end

	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_strings();
		directed_words = words_sent;
		while (words_sent < directed_words + RANDOM_WORDS) random_string();
		item_valid <= 1'b0;

		// Let the remaining text drain, then watch for stray words.
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d input words forming %0d strings, %0d of them carrying a UTF-8 error.",
			words_sent, sb.strings_closed, sb.strings_bad);
		$display("Checked %0d text words, %0d mismatched.", sb.words_checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("json_string_escape_utf8_check verification clean");
		end else begin
			$display("json_string_escape_utf8_check verification failed");
		end
		$finish;
	end

endmodule
